/* sv/assert_macros.svh */
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define QOI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qoi encoder assertion failed");

// antecedent implies consequent in the next cycle
`define QOI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qoi encoder assertion failed");

`endif

/* sv/qoi_pkg.sv */
// ---------------------------------------------------------------------------
// qoi_pkg
// Shared types and constants of the QOI image encoder.
// ---------------------------------------------------------------------------
package qoi_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 8'd1;

   // stream constants
   localparam logic [31:0] QOI_MAGIC    = 32'h716F6966;
   localparam logic [7:0]  QOI_CHANNELS = 8'd4;
   localparam logic [7:0]  QOI_END_TAIL = 8'h01;
   localparam logic [4:0]  HDR_LEN      = 5'd14;
   localparam logic [4:0]  END_LEN      = 5'd8;

   // op tags
   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF  = 2'b01;
   localparam logic [1:0] TAG_LUMA  = 2'b10;
   localparam logic [1:0] TAG_RUN   = 2'b11;
   localparam logic [7:0] TAG_RGB   = 8'hFE;
   localparam logic [7:0] TAG_RGBA  = 8'hFF;

   localparam logic [5:0]  RUN_LIMIT  = 6'd62;
   localparam logic [31:0] PIXEL_INIT = 32'h0000_00FF;

   // one classified pixel as a list of byte groups to send
   typedef struct packed {
      logic            hdr;
      logic            run_en;
      logic [7:0]      run_byte;
      logic [2:0]      op_len;
      logic [4:0][7:0] op_bytes;
      logic            eoi;
   } qoi_cmd_type;

endpackage

/* sv/qoi_ifs.sv */
// ---------------------------------------------------------------------------
// qoi channel interfaces
// Pixel input, byte output and register write channels.
// ---------------------------------------------------------------------------
interface qoi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;
   logic [7:0] pixel_alpha;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                   input ready);
   modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                 output ready);
endinterface

interface qoi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_item;
   logic       end_of_image;

   modport source (output valid, out_byte, last_of_item, end_of_image, input ready);
   modport sink (input valid, out_byte, last_of_item, end_of_image, output ready);
endinterface

interface qoi_csr_if;
   logic                               valid;
   logic                               ready;
   logic [qoi_pkg::CSR_INDEX_W-1:0]    index;
   logic [qoi_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/qoi_front.sv */
// ---------------------------------------------------------------------------
// qoi_front
// Takes pixels, looks up the colour index and classifies each pixel into
// the byte groups it produces. Holds previous pixel, run and pixel count.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_front (
   input  logic                 clock,
   input  logic                 reset,
   qoi_req_if.sink              req,
   input  logic [31:0]          total_pixels,
   output logic                 push,
   output qoi_pkg::qoi_cmd_type push_cmd,
   input  logic                 q_full
);

   function automatic logic [5:0] qoi_hash(input logic [31:0] px);
      logic [5:0] h;
      h = px[29:24] * 6'd3 + px[21:16] * 6'd5 + px[13:8] * 6'd7 + px[5:0] * 6'd11;
      return h;
   endfunction

   logic [31:0] index_mem [64];

   logic        p1_valid_ff, p1_valid_in;
   logic [31:0] p1_px_ff;
   logic [5:0]  p1_hash_ff;
   logic [31:0] rd_raw_ff;
   logic        byp_ff, byp_in;
   logic [31:0] byp_data_ff;
   logic        ent_valid_ff, ent_valid_in;
   logic [63:0] valid_bits_ff, valid_bits_in;
   logic [31:0] prev_ff, prev_in;
   logic [5:0]  run_ff, run_in;
   logic [31:0] seen_ff, seen_in;

   logic        accept, proc, need_push, last, same, hit, wr_en;
   logic [31:0] px_in, entry;
   logic [5:0]  hash_in, run_inc;
   logic [32:0] seen_inc;
   logic [7:0]  pr, pg, pb, pa, cr, cg, cb, ca;
   logic signed [7:0] vr, vg, vb, vgr, vgb;
   logic [7:0]  dr2, dg2, db2, lg, lr, lb;
   qoi_pkg::qoi_cmd_type cmd;

   assign px_in   = {req.pixel_red, req.pixel_green, req.pixel_blue, req.pixel_alpha};
   assign hash_in = qoi_hash(px_in);
   assign accept  = req.valid && req.ready;
   assign req.ready = !p1_valid_ff || proc;

   // index entry seen by the pixel in stage one, with write forwarding
   assign entry = !ent_valid_ff ? 32'h0 : (byp_ff ? byp_data_ff : rd_raw_ff);

   assign {cr, cg, cb, ca} = p1_px_ff;
   assign {pr, pg, pb, pa} = prev_ff;

   assign seen_inc = {1'b0, seen_ff} + 33'd1;
   assign last     = seen_inc >= {1'b0, total_pixels};
   assign same     = p1_px_ff == prev_ff;
   assign hit      = entry == p1_px_ff;
   assign run_inc  = run_ff + 6'd1;

   assign vr  = cr - pr;
   assign vg  = cg - pg;
   assign vb  = cb - pb;
   assign vgr = vr - vg;
   assign vgb = vb - vg;
   assign dr2 = vr + 8'sd2;
   assign dg2 = vg + 8'sd2;
   assign db2 = vb + 8'sd2;
   assign lg  = vg + 8'sd32;
   assign lr  = vgr + 8'sd8;
   assign lb  = vgb + 8'sd8;

   always_comb begin
      cmd          = '0;
      cmd.hdr      = seen_ff == 32'd0;
      cmd.eoi      = last;
      run_in       = 6'd0;
      wr_en        = 1'b0;
      if (same) begin
         if (run_inc >= qoi_pkg::RUN_LIMIT || last) begin
            cmd.run_en   = 1'b1;
            cmd.run_byte = {qoi_pkg::TAG_RUN, run_ff};
         end else begin
            run_in = run_inc;
         end
      end else begin
         if (run_ff != 6'd0) begin
            cmd.run_en   = 1'b1;
            cmd.run_byte = {qoi_pkg::TAG_RUN, run_ff - 6'd1};
         end
         if (hit) begin
            cmd.op_len      = 3'd1;
            cmd.op_bytes[0] = {qoi_pkg::TAG_INDEX, p1_hash_ff};
         end else begin
            wr_en = 1'b1;
            if (ca == pa) begin
               if (vr >= -8'sd2 && vr <= 8'sd1 && vg >= -8'sd2 && vg <= 8'sd1 &&
                   vb >= -8'sd2 && vb <= 8'sd1) begin
                  cmd.op_len      = 3'd1;
                  cmd.op_bytes[0] = {qoi_pkg::TAG_DIFF, dr2[1:0], dg2[1:0], db2[1:0]};
               end else if (vg >= -8'sd32 && vg <= 8'sd31 && vgr >= -8'sd8 &&
                            vgr <= 8'sd7 && vgb >= -8'sd8 && vgb <= 8'sd7) begin
                  cmd.op_len      = 3'd2;
                  cmd.op_bytes[0] = {qoi_pkg::TAG_LUMA, lg[5:0]};
                  cmd.op_bytes[1] = {lr[3:0], lb[3:0]};
               end else begin
                  cmd.op_len      = 3'd4;
                  cmd.op_bytes[0] = qoi_pkg::TAG_RGB;
                  cmd.op_bytes[1] = cr;
                  cmd.op_bytes[2] = cg;
                  cmd.op_bytes[3] = cb;
               end
            end else begin
               cmd.op_len      = 3'd5;
               cmd.op_bytes[0] = qoi_pkg::TAG_RGBA;
               cmd.op_bytes[1] = cr;
               cmd.op_bytes[2] = cg;
               cmd.op_bytes[3] = cb;
               cmd.op_bytes[4] = ca;
            end
         end
      end
   end

   assign need_push = cmd.hdr || cmd.run_en || (cmd.op_len != 3'd0) || cmd.eoi;
   assign proc      = p1_valid_ff && (!need_push || !q_full);
   assign push      = proc && need_push;
   assign push_cmd  = cmd;

   always_comb begin
      p1_valid_in   = p1_valid_ff;
      byp_in        = byp_ff;
      ent_valid_in  = ent_valid_ff;
      valid_bits_in = valid_bits_ff;
      prev_in       = prev_ff;
      seen_in       = seen_ff;
      if (accept) begin
         p1_valid_in  = 1'b1;
         byp_in       = proc && wr_en && (p1_hash_ff == hash_in);
         ent_valid_in = !(proc && last) && (valid_bits_ff[hash_in] || byp_in);
      end else if (proc) begin
         p1_valid_in = 1'b0;
      end
      if (proc) begin
         if (last) begin
            valid_bits_in = '0;
            prev_in       = qoi_pkg::PIXEL_INIT;
            seen_in       = 32'd0;
         end else begin
            if (wr_en) valid_bits_in[p1_hash_ff] = 1'b1;
            prev_in = p1_px_ff;
            seen_in = seen_inc[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff   <= 1'b0;
         byp_ff        <= 1'b0;
         ent_valid_ff  <= 1'b0;
         valid_bits_ff <= '0;
         prev_ff       <= qoi_pkg::PIXEL_INIT;
         run_ff        <= 6'd0;
         seen_ff       <= 32'd0;
      end else begin
         p1_valid_ff   <= p1_valid_in;
         byp_ff        <= byp_in;
         ent_valid_ff  <= ent_valid_in;
         valid_bits_ff <= valid_bits_in;
         prev_ff       <= prev_in;
         if (proc) run_ff <= last ? 6'd0 : run_in;
         seen_ff       <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_px_ff    <= px_in;
         p1_hash_ff  <= hash_in;
         byp_data_ff <= p1_px_ff;
      end
   end

   // colour index memory, registered read
   always_ff @(posedge clock) begin
      if (proc && wr_en) index_mem[p1_hash_ff] <= p1_px_ff;
      if (accept) rd_raw_ff <= index_mem[hash_in];
   end

   `QOI_ASSERT_NXT(a_clear_at_end, clock, reset, proc && last, seen_ff == 32'd0 && run_ff == 6'd0 && valid_bits_ff == '0)
   `QOI_ASSERT_IMP(a_run_bound, clock, reset, 1'b1, run_ff < qoi_pkg::RUN_LIMIT)

endmodule

/* sv/qoi_queue.sv */
// ---------------------------------------------------------------------------
// qoi_queue
// Small queue of classified pixels between the front and the serializer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qoi_pkg::qoi_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output qoi_pkg::qoi_cmd_type head_cmd,
   output logic                 empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   qoi_pkg::qoi_cmd_type entries [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries[wr_ptr_ff] <= push_cmd;
   end

   `QOI_ASSERT_IMP(a_no_overflow, clock, reset, push && !pop, !full)
   `QOI_ASSERT_IMP(a_no_underflow, clock, reset, pop, !empty)

endmodule

/* sv/qoi_back.sv */
// ---------------------------------------------------------------------------
// qoi_back
// Serializes each queued pixel into stream bytes: header, run, op, end
// marker, through a registered output word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  qoi_pkg::qoi_cmd_type head_cmd,
   input  logic                 empty,
   output logic                 pop,
   input  logic [15:0]          image_width,
   input  logic [15:0]          image_height,
   qoi_rsp_if.source            rsp
);

   function automatic logic [7:0] hdr_byte(input logic [3:0] pos,
                                           input logic [15:0] w,
                                           input logic [15:0] h);
      logic [7:0] v;
      case (pos)
         4'd0:    v = qoi_pkg::QOI_MAGIC[31:24];
         4'd1:    v = qoi_pkg::QOI_MAGIC[23:16];
         4'd2:    v = qoi_pkg::QOI_MAGIC[15:8];
         4'd3:    v = qoi_pkg::QOI_MAGIC[7:0];
         4'd6:    v = w[15:8];
         4'd7:    v = w[7:0];
         4'd10:   v = h[15:8];
         4'd11:   v = h[7:0];
         4'd12:   v = qoi_pkg::QOI_CHANNELS;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] op_byte(input logic [2:0] idx,
                                          input logic [4:0][7:0] bytes);
      logic [7:0] v;
      case (idx)
         3'd0:    v = bytes[0];
         3'd1:    v = bytes[1];
         3'd2:    v = bytes[2];
         3'd3:    v = bytes[3];
         3'd4:    v = bytes[4];
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   logic [4:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff, out_eoi_ff;

   logic [4:0] n_hdr, b2, b3, total;
   logic [4:0] op_off;
   logic       load, last_byte;
   logic [7:0] cur_byte;

   assign n_hdr     = head_cmd.hdr ? qoi_pkg::HDR_LEN : 5'd0;
   assign b2        = n_hdr + {4'b0, head_cmd.run_en};
   assign b3        = b2 + {2'b0, head_cmd.op_len};
   assign total     = b3 + (head_cmd.eoi ? qoi_pkg::END_LEN : 5'd0);
   assign last_byte = pos_ff == total - 5'd1;
   assign op_off    = pos_ff - b2;

   always_comb begin
      if (pos_ff < n_hdr) begin
         cur_byte = hdr_byte(pos_ff[3:0], image_width, image_height);
      end else if (pos_ff < b2) begin
         cur_byte = head_cmd.run_byte;
      end else if (pos_ff < b3) begin
         cur_byte = op_byte(op_off[2:0], head_cmd.op_bytes);
      end else begin
         cur_byte = last_byte ? qoi_pkg::QOI_END_TAIL : 8'h00;
      end
   end

   // output word is free or being taken this cycle
   assign load = !empty && (!out_valid_ff || rsp.ready);
   assign pop  = load && last_byte;

   always_comb begin
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         pos_in       = last_byte ? 5'd0 : pos_ff + 5'd1;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= cur_byte;
         out_last_ff <= last_byte;
         out_eoi_ff  <= last_byte && head_cmd.eoi;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_byte     = out_byte_ff;
   assign rsp.last_of_item = out_last_ff;
   assign rsp.end_of_image = out_eoi_ff;

   `QOI_ASSERT_IMP(a_eoi_is_last, clock, reset, out_valid_ff && out_eoi_ff, out_last_ff)

endmodule

/* sv/qoi_image_encoder_top.sv */
// A pixel is registered in stage one, queued, then sent through the output
// register. Throughput: one pixel per cycle while each yields at most one byte
// and the receiver is ready; otherwise bounded by the output port at one byte per
// cycle (header 14, ops up to 5, end marker 8), with the queue absorbing short bursts.
// Reset (synchronous, active high): clears index valid bits, run, pixel count
// and queue, sets the previous pixel to 0x000000FF; width and height registers go to 1.
// ---------------------------------------------------------------------------
// qoi_image_encoder_top
// QOI encoder: pixel front end, command queue and byte serializer.
// ---------------------------------------------------------------------------
module qoi_image_encoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   qoi_req_if.sink    req,
   qoi_rsp_if.source  rsp,
   qoi_csr_if.sink    csr
);

   logic [15:0] width_ff, height_ff;
   logic [31:0] total_ff, total_in;

   qoi_pkg::qoi_cmd_type push_cmd, head_cmd;
   logic push, pop, q_full, q_empty;

   assign csr.ready = 1'b1;
   assign total_in  = width_ff * height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
         total_ff  <= 32'd1;
      end else begin
         total_ff <= total_in;
         if (csr.valid) begin
            case (csr.index)
               qoi_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr.data;
               qoi_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr.data;
               default: ;
            endcase
         end
      end
   end

   qoi_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .total_pixels (total_ff),
      .push         (push),
      .push_cmd     (push_cmd),
      .q_full       (q_full)
   );

   qoi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   qoi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .empty        (q_empty),
      .pop          (pop),
      .image_width  (width_ff),
      .image_height (height_ff),
      .rsp          (rsp)
   );

endmodule

/* tb/sv/qoi_image_encoder_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qoi_image_encoder_top_tb
// Streams RGBA pixels into the QOI encoder through its valid/ready channels.
// The sender and receiver stall at random. Register writes happen only while
// the encoder is idle. A behavioral encoder runs alongside and checks every
// stream byte and its flags. A short script of images comes first, then random
// images with mid-image size changes, zero sizes and long runs.
// ---------------------------------------------------------------------------
module qoi_image_encoder_top_tb;

   localparam int TIMEOUT_NS    = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 300;
   localparam int REPORT_MAX    = 10;
   localparam int PALETTE_SIZE  = 8;
   localparam int SCRIPT_ROWS   = 26;
   localparam int WORD_CAP      = 120;

   localparam logic [7:0]                      COLORSPACE_SRGB = 8'd0;
   localparam logic [qoi_pkg::CSR_INDEX_W-1:0] CSR_JUNK        = '1;

   typedef struct packed {
      logic [7:0] red, green, blue, alpha;
   } pixel_type;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       eoi;
   } stream_byte_type;

   typedef struct packed {
      logic        cfg_en;
      logic [15:0] cfg_width;
      logic [15:0] cfg_height;
      pixel_type   px;
      logic        typed;
      logic [7:0]  lead;
   } script_row_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_mode_type;
   typedef enum logic [2:0] {
      CFG_ZERO_W, CFG_ZERO_H, CFG_WIDE, CFG_JUNK, CFG_MEDIUM, CFG_SMALL
   } phase_kind_type;

   // lead: first byte after any header, typed in where it is obvious
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{1'b0, 16'd0, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd255}, 1'b1, {qoi_pkg::TAG_RUN, 6'd0}},
      '{1'b1, 16'd3, 16'd7, '{8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd1, 8'd1, 8'd1, 8'd255}, 1'b1, {qoi_pkg::TAG_RUN, 6'd1}},
      '{1'b0, 16'd0, 16'd0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd30, 8'd31, 8'd38, 8'd255}, 1'b1, qoi_pkg::TAG_RGB},
      '{1'b0, 16'd0, 16'd0, '{8'd246, 8'd255, 8'd13, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd28, 8'd30, 8'd36, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd28, 8'd30, 8'd36, 8'd0}, 1'b1, qoi_pkg::TAG_RGBA},
      '{1'b0, 16'd0, 16'd0, '{8'd1, 8'd1, 8'd1, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
        {qoi_pkg::TAG_RUN, 6'd0}},
      '{1'b0, 16'd0, 16'd0, '{8'd128, 8'd127, 8'd128, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd0, 8'd255, 8'd128, 8'd128}, 1'b1, qoi_pkg::TAG_RGBA},
      '{1'b0, 16'd0, 16'd0, '{8'd127, 8'd128, 8'd127, 8'd128}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd255, 8'd0, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd255, 8'd0, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd255, 8'd0, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd170, 8'd85, 8'd170, 8'd85}, 1'b1, {qoi_pkg::TAG_RUN, 6'd1}},
      '{1'b0, 16'd0, 16'd0, '{8'd170, 8'd85, 8'd170, 8'd85}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd170, 8'd85, 8'd170, 8'd85}, 1'b1, {qoi_pkg::TAG_RUN, 6'd1}},
      '{1'b1, 16'd0, 16'd9, '{8'd18, 8'd52, 8'd86, 8'd120}, 1'b1, qoi_pkg::TAG_RGBA},
      '{1'b1, 16'hFFFF, 16'hFFFF, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{1'b0, 16'd0, 16'd0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
      '{1'b1, 16'd1, 16'd1, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
        {qoi_pkg::TAG_RUN, 6'd1}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   qoi_req_if pix_ch ();
   qoi_rsp_if byte_ch ();
   qoi_csr_if csr_ch ();

   qoi_image_encoder_top uut (
      .clock (clock),
      .reset (reset),
      .req   (pix_ch),
      .rsp   (byte_ch),
      .csr   (csr_ch)
   );

   always #1 clock = ~clock;

   // behavioral encoder state
   logic [15:0] img_width;
   logic [15:0] img_height;
   pixel_type   seen_colors [64];
   pixel_type   prev_px;
   logic [5:0]  run_len;
   logic [31:0] pixels_seen;

   stream_byte_type pending_bytes [$];
   int              mismatches = 0;

   // stimulus pacing
   pixel_type   last_sent = '0;
   pixel_type   palette [PALETTE_SIZE];
   int unsigned run_left = 0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   bit          steady = 1'b0;
   bit          hold_request = 1'b0;

   function automatic void clear_image();
      for (int k = 0; k < 64; k++) seen_colors[k] = '0;
      prev_px = pixel_type'(qoi_pkg::PIXEL_INIT);
      run_len = '0;
      pixels_seen = '0;
   endfunction

   function automatic void apply_reg(input logic [qoi_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [qoi_pkg::CSR_DATA_W-1:0] value);
      if (idx == qoi_pkg::CSR_IMAGE_WIDTH) img_width = value;
      else if (idx == qoi_pkg::CSR_IMAGE_HEIGHT) img_height = value;
   endfunction

   function automatic void emit(input logic [7:0] code, input logic eoi);
      stream_byte_type b;
      b.code = code;
      b.last = 1'b0;
      b.eoi = eoi;
      pending_bytes.push_back(b);
   endfunction

   // appends the bytes one pixel causes, returns how many
   function automatic int unsigned encode_pixel(input pixel_type px);
      int unsigned     first = pending_bytes.size();
      logic [31:0]     total;
      logic [32:0]     seen_next;
      logic            last_px;
      logic [31:0]     hash_sum;
      logic [5:0]      slot;
      logic signed [7:0] dr, dg, db, dgr, dgb;
      stream_byte_type tail;

      total = {16'd0, img_width} * {16'd0, img_height};
      seen_next = {1'b0, pixels_seen} + 33'd1;
      last_px = seen_next >= {1'b0, total};

      if (pixels_seen == 0) begin
         for (int k = 3; k >= 0; k--) emit(qoi_pkg::QOI_MAGIC[8*k +: 8], 1'b0);
         emit(8'd0, 1'b0);
         emit(8'd0, 1'b0);
         emit(img_width[15:8], 1'b0);
         emit(img_width[7:0], 1'b0);
         emit(8'd0, 1'b0);
         emit(8'd0, 1'b0);
         emit(img_height[15:8], 1'b0);
         emit(img_height[7:0], 1'b0);
         emit(qoi_pkg::QOI_CHANNELS, 1'b0);
         emit(COLORSPACE_SRGB, 1'b0);
      end

      if (px == prev_px) begin
         run_len = run_len + 6'd1;
         if (run_len >= qoi_pkg::RUN_LIMIT || last_px) begin
            emit({qoi_pkg::TAG_RUN, run_len - 6'd1}, 1'b0);
            run_len = '0;
         end
      end else begin
         if (run_len != 0) begin
            emit({qoi_pkg::TAG_RUN, run_len - 6'd1}, 1'b0);
            run_len = '0;
         end
         hash_sum = px.red * 3 + px.green * 5 + px.blue * 7 + px.alpha * 11;
         slot = hash_sum[5:0];
         if (seen_colors[slot] == px) begin
            emit({qoi_pkg::TAG_INDEX, slot}, 1'b0);
         end else begin
            seen_colors[slot] = px;
            if (px.alpha == prev_px.alpha) begin
               // channel deltas wrap to 8 bits
               dr = px.red - prev_px.red;
               dg = px.green - prev_px.green;
               db = px.blue - prev_px.blue;
               dgr = dr - dg;
               dgb = db - dg;
               if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
                  emit({qoi_pkg::TAG_DIFF, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)}, 1'b0);
               end else if (dg >= -32 && dg <= 31 && dgr >= -8 && dgr <= 7 &&
                            dgb >= -8 && dgb <= 7) begin
                  emit({qoi_pkg::TAG_LUMA, 6'(dg + 32)}, 1'b0);
                  emit({4'(dgr + 8), 4'(dgb + 8)}, 1'b0);
               end else begin
                  emit(qoi_pkg::TAG_RGB, 1'b0);
                  emit(px.red, 1'b0);
                  emit(px.green, 1'b0);
                  emit(px.blue, 1'b0);
               end
            end else begin
               emit(qoi_pkg::TAG_RGBA, 1'b0);
               emit(px.red, 1'b0);
               emit(px.green, 1'b0);
               emit(px.blue, 1'b0);
               emit(px.alpha, 1'b0);
            end
         end
      end

      prev_px = px;
      pixels_seen = seen_next[31:0];

      if (last_px) begin
         repeat (7) emit(8'd0, 1'b0);
         emit(qoi_pkg::QOI_END_TAIL, 1'b1);
         clear_image();
      end

      if (pending_bytes.size() > first) begin
         tail = pending_bytes[pending_bytes.size() - 1];
         tail.last = 1'b1;
         pending_bytes[pending_bytes.size() - 1] = tail;
      end
      return pending_bytes.size() - first;
   endfunction

   function automatic pixel_type next_pixel();
      pixel_type   p = last_sent;
      int unsigned pick;
      int          dg;

      if (run_left > 0) begin
         run_left--;
         return p;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         run_left = $urandom_range(55, 70);
      end else if (pick < 20) begin
         run_left = $urandom_range(0, 3);
      end else if (pick < 35) begin
         p = palette[$urandom_range(0, PALETTE_SIZE - 1)];
      end else if (pick < 55) begin
         p.red = p.red + 8'($urandom_range(0, 3)) - 8'd2;
         p.green = p.green + 8'($urandom_range(0, 3)) - 8'd2;
         p.blue = p.blue + 8'($urandom_range(0, 3)) - 8'd2;
      end else if (pick < 72) begin
         dg = int'($urandom_range(0, 63)) - 32;
         p.green = p.green + 8'(dg);
         p.red = p.red + 8'(dg + int'($urandom_range(0, 15)) - 8);
         p.blue = p.blue + 8'(dg + int'($urandom_range(0, 15)) - 8);
      end else if (pick < 88) begin
         p.red = 8'($urandom);
         p.green = 8'($urandom);
         p.blue = 8'($urandom);
      end else begin
         p = pixel_type'($urandom);
      end
      if ($urandom_range(0, 7) == 0) palette[$urandom_range(0, PALETTE_SIZE - 1)] = p;
      return p;
   endfunction

   function automatic void flag_mismatch(input string what, input stream_byte_type want,
                                         input stream_byte_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t mismatch, %s: expected %02h last %0b eoi %0b, got %02h last %0b eoi %0b",
                  $time, what, want.code, want.last, want.eoi, got.code, got.last, got.eoi);
   endfunction

   // output checker
   always @(posedge clock) begin
      stream_byte_type got;
      stream_byte_type want;
      if (!reset && byte_ch.valid && byte_ch.ready) begin
         got.code = byte_ch.out_byte;
         got.last = byte_ch.last_of_item;
         got.eoi = byte_ch.end_of_image;
         if (pending_bytes.size() == 0) begin
            flag_mismatch("no word pending", '0, got);
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want) flag_mismatch("wrong word", want, got);
         end
      end
   end

   // receiver: stall patterns, plus long hold-offs on request
   initial begin : sink_drive
      sink_mode_type sink_mode;
      int unsigned   pat_left;
      int unsigned   hold_left;
      sink_mode = SINK_OPEN;
      pat_left = 0;
      hold_left = 0;
      byte_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            byte_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            byte_ch.ready <= 1'b0;
         end else begin
            if (pat_left == 0) begin
               sink_mode = sink_mode_type'($urandom_range(0, 3));
               pat_left = $urandom_range(8, 64);
            end
            pat_left--;
            case (sink_mode)
               SINK_OPEN:   byte_ch.ready <= 1'b1;
               SINK_COIN:   byte_ch.ready <= 1'($urandom_range(0, 1));
               SINK_MOSTLY: byte_ch.ready <= ($urandom_range(0, 7) != 0);
               default:     byte_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            pix_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_pixel(input pixel_type px, input logic typed, input logic [7:0] lead);
      int unsigned     head;
      int unsigned     base;
      int unsigned     cnt;
      stream_byte_type fix;
      pace_sender();
      @(negedge clock);
      pix_ch.valid <= 1'b1;
      pix_ch.pixel_red <= px.red;
      pix_ch.pixel_green <= px.green;
      pix_ch.pixel_blue <= px.blue;
      pix_ch.pixel_alpha <= px.alpha;
      do @(posedge clock); while (!pix_ch.ready);
      head = (pixels_seen == 0) ? qoi_pkg::HDR_LEN : 0;
      base = pending_bytes.size();
      cnt = encode_pixel(px);
      if (typed && cnt > head) begin
         fix = pending_bytes[base + head];
         fix.code = lead;
         pending_bytes[base + head] = fix;
      end
      last_sent = px;
      items_sent++;
   endtask

   // stop sending and wait until the encoder has gone quiet
   task automatic settle();
      @(negedge clock);
      pix_ch.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [qoi_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [qoi_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      apply_reg(idx, value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : run_timeout
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      phase_kind_type kind;
      int unsigned    pick;
      int unsigned    n;
      int unsigned    left;
      logic [31:0]    total;
      logic [31:0]    rem;
      bit             first_phase;
      bit             full_image;

      pix_ch.valid = 1'b0;
      pix_ch.pixel_red = '0;
      pix_ch.pixel_green = '0;
      pix_ch.pixel_blue = '0;
      pix_ch.pixel_alpha = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      img_width = 16'd1;
      img_height = 16'd1;
      first_phase = 1'b1;
      full_image = 1'b0;
      clear_image();
      for (int k = 0; k < PALETTE_SIZE; k++) palette[k] = pixel_type'($urandom);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         if (SCRIPT[i].cfg_en) begin
            settle();
            write_reg(CSR_JUNK, ~SCRIPT[i].cfg_width);
            write_reg(qoi_pkg::CSR_IMAGE_WIDTH, SCRIPT[i].cfg_width);
            write_reg(qoi_pkg::CSR_IMAGE_HEIGHT, SCRIPT[i].cfg_height);
         end
         send_pixel(SCRIPT[i].px, SCRIPT[i].typed, SCRIPT[i].lead);
      end

      while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS) begin
         settle();
         steady = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PALETTE_SIZE; k++)
            palette[k] = ($urandom_range(0, 3) == 0) ? last_sent : pixel_type'($urandom);

         if (first_phase) begin
            // long receiver hold while the sender keeps pushing, plus a run past the limit
            first_phase = 1'b0;
            full_image = 1'b1;
            write_reg(qoi_pkg::CSR_IMAGE_WIDTH, 16'd8);
            write_reg(qoi_pkg::CSR_IMAGE_HEIGHT, 16'd10);
            hold_request = 1'b1;
            run_left = $urandom_range(62, 70);
            kind = CFG_MEDIUM;
         end else begin
            full_image = 1'b0;
            pick = $urandom_range(0, 19);
            kind = (pick == 0) ? CFG_ZERO_W : (pick == 1) ? CFG_ZERO_H :
                   (pick == 2) ? CFG_WIDE : (pick == 3) ? CFG_JUNK :
                   (pick < 8) ? CFG_MEDIUM : CFG_SMALL;
            if ($urandom_range(0, 11) == 0) hold_request = 1'b1;
            case (kind)
               CFG_ZERO_W: write_reg(qoi_pkg::CSR_IMAGE_WIDTH, '0);
               CFG_ZERO_H: write_reg(qoi_pkg::CSR_IMAGE_HEIGHT, '0);
               CFG_WIDE: begin
                  write_reg(qoi_pkg::CSR_IMAGE_WIDTH,
                            qoi_pkg::CSR_DATA_W'($urandom_range(0, 65535)));
                  write_reg(qoi_pkg::CSR_IMAGE_HEIGHT, ($urandom_range(0, 1) == 1) ? '1 :
                            qoi_pkg::CSR_DATA_W'($urandom_range(0, 65535)));
               end
               CFG_JUNK: write_reg(qoi_pkg::CSR_INDEX_W'($urandom_range(
                                      qoi_pkg::CSR_IMAGE_HEIGHT + 1,
                                      (1 << qoi_pkg::CSR_INDEX_W) - 1)),
                                   qoi_pkg::CSR_DATA_W'($urandom));
               CFG_MEDIUM: begin
                  write_reg(qoi_pkg::CSR_IMAGE_WIDTH,
                            qoi_pkg::CSR_DATA_W'($urandom_range(1, 16)));
                  write_reg(qoi_pkg::CSR_IMAGE_HEIGHT,
                            qoi_pkg::CSR_DATA_W'($urandom_range(1, 8)));
               end
               default: begin
                  write_reg(qoi_pkg::CSR_IMAGE_HEIGHT,
                            qoi_pkg::CSR_DATA_W'($urandom_range(1, 6)));
                  write_reg(qoi_pkg::CSR_IMAGE_WIDTH,
                            qoi_pkg::CSR_DATA_W'($urandom_range(1, 6)));
               end
            endcase
         end

         // pixels left in the current image, cut short now and then
         total = {16'd0, img_width} * {16'd0, img_height};
         if (total <= pixels_seen) rem = $urandom_range(1, 4);
         else rem = total - pixels_seen;
         n = (rem > WORD_CAP) ? WORD_CAP : rem;
         if (!full_image && (rem > WORD_CAP || $urandom_range(0, 3) == 0))
            n = $urandom_range(1, n);
         left = SCRIPT_ROWS + RANDOM_ITEMS - items_sent;
         if (n > left) n = left;

         repeat (n) send_pixel(next_pixel(), 1'b0, 8'd0);
      end

      settle();
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* qoi_image_encoder_top.f */
+incdir+sv
sv/qoi_pkg.sv
sv/qoi_ifs.sv
sv/qoi_front.sv
sv/qoi_queue.sv
sv/qoi_back.sv
sv/qoi_image_encoder_top.sv
tb/sv/qoi_image_encoder_top_tb.sv
